FILE: rtl/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg: shared widths, constants and stage types
// Widths of the pair force pipeline, register indexes and reset values, and
// the structs that carry an item between the pipeline sections.
// ----------------------------------------------------------------------------
package gpf_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned IN_W      = 32;   // input fields and registers
  localparam int unsigned OUT_W     = 48;   // force components
  localparam int unsigned MAG_W     = IN_W + 1;       // |a - b|
  localparam int unsigned GM_W      = 2 * IN_W;       // G * mass a
  localparam int unsigned D2_W      = 2 * MAG_W;      // dx^2 + dy^2
  localparam int unsigned ROOT_W    = 34;             // isqrt result bits
  localparam int unsigned SQ_STAGES = ROOT_W;
  localparam int unsigned SQ_REM_W  = 2 * ROOT_W;
  localparam int unsigned DIST_W    = 33;             // dist < 2^33
  localparam int unsigned DC_W      = 2 * DIST_W;     // 33x33 products
  localparam int unsigned K3_W      = 3 * IN_W;       // G * ma * mb
  localparam int unsigned PX_W      = IN_W + MAG_W;   // k3 word * magnitude
  localparam int unsigned NUM_W     = 128;            // k3 * magnitude
  localparam int unsigned DEN_W     = 3 * DIST_W;     // dist^3
  localparam int unsigned DREM_W    = DEN_W + 1;      // divider remainder
  localparam int unsigned Q_W       = OUT_W;          // quotient bits kept
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP    = CFG_IDX_W'(1);

  localparam logic [IN_W-1:0] GRAV_RESET = IN_W'(1) << FRAC_BITS;
  localparam logic [IN_W-1:0] MIN_RESET  = IN_W'(5) << FRAC_BITS;

  localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

  // lane 0 is x, lane 1 is y
  typedef struct packed {
    logic [K3_W-1:0]            k3;
    logic [1:0][MAG_W-1:0]      mag;
    logic [1:0]                 neg;
    logic                       app;
  } gpf_side_t;

  typedef struct packed {
    logic [1:0][NUM_W-1:0]      num;
    logic [DEN_W-1:0]           den;
    logic [1:0]                 neg;
    logic [1:0]                 big;
    logic                       app;
  } gpf_prod_t;

  typedef struct packed {
    logic [DREM_W-1:0]          rem;
    logic [Q_W-1:0]             low;
    logic [Q_W-1:0]             q;
  } gpf_dlane_t;

  typedef struct packed {
    gpf_dlane_t [1:0]           lane;
    logic [DEN_W-1:0]           den;
    logic [1:0]                 neg;
    logic [1:0]                 big;
    logic                       app;
  } gpf_dstage_t;

  typedef struct packed {
    logic [1:0][Q_W-1:0]        q;
    logic [1:0]                 neg;
    logic [1:0]                 big;
    logic                       app;
  } gpf_quot_t;

endpackage

FILE: rtl/gpf_front.sv
// ----------------------------------------------------------------------------
// gpf_front: displacement, squared distance and mass product
// Five stages: differences, magnitudes and G*ma, squares and partial
// products, sums, distance test against the squared minimum separation.
// ----------------------------------------------------------------------------
module gpf_front import gpf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] a_x_i,
  input  logic signed [IN_W-1:0] a_y_i,
  input  logic [IN_W-1:0]        a_mass_i,
  input  logic signed [IN_W-1:0] b_x_i,
  input  logic signed [IN_W-1:0] b_y_i,
  input  logic [IN_W-1:0]        b_mass_i,
  input  logic [IN_W-1:0]        grav_const_i,
  input  logic [IN_W-1:0]        min_sep_i,
  output logic                   valid_o,
  output logic [D2_W-1:0]        d2_o,
  output gpf_side_t              side_o
);

  logic [4:0]                 vld_q;
  logic [1:0][MAG_W-1:0]      d_s1_q;
  logic [IN_W-1:0]            ma_s1_q, mb_s1_q, mb_s2_q;
  logic [1:0][MAG_W-1:0]      mag_s2_q, mag_s3_q, mag_s4_q;
  logic [1:0]                 neg_s2_q, neg_s3_q, neg_s4_q;
  logic [GM_W-1:0]            gm_s2_q;
  logic [1:0][GM_W-1:0]       pk_s3_q;
  logic [1:0][D2_W-1:0]       sq_s3_q;
  logic [D2_W-1:0]            d2_s4_q, d2_q;
  logic [K3_W-1:0]            k3_s4_q;
  logic [GM_W-1:0]            min_sq_q;
  gpf_side_t                  side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // squared threshold follows register; user must change it only while idle
  always_ff @(posedge clk_i) begin
    min_sq_q <= GM_W'(min_sep_i) * GM_W'(min_sep_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // exact 33-bit differences
      d_s1_q[0] <= {a_x_i[IN_W-1], a_x_i} - {b_x_i[IN_W-1], b_x_i};
      d_s1_q[1] <= {a_y_i[IN_W-1], a_y_i} - {b_y_i[IN_W-1], b_y_i};
      ma_s1_q   <= a_mass_i;
      mb_s1_q   <= b_mass_i;

      for (int l = 0; l < 2; l++) begin
        neg_s2_q[l] <= d_s1_q[l][MAG_W-1];
        mag_s2_q[l] <= d_s1_q[l][MAG_W-1] ? MAG_W'(~d_s1_q[l] + MAG_W'(1)) : d_s1_q[l];
      end
      gm_s2_q <= GM_W'(grav_const_i) * GM_W'(ma_s1_q);
      mb_s2_q <= mb_s1_q;

      for (int l = 0; l < 2; l++) begin
        sq_s3_q[l] <= D2_W'(mag_s2_q[l]) * D2_W'(mag_s2_q[l]);
      end
      pk_s3_q[0] <= GM_W'(gm_s2_q[IN_W-1:0]) * GM_W'(mb_s2_q);
      pk_s3_q[1] <= GM_W'(gm_s2_q[GM_W-1:IN_W]) * GM_W'(mb_s2_q);
      mag_s3_q   <= mag_s2_q;
      neg_s3_q   <= neg_s2_q;

      d2_s4_q  <= sq_s3_q[0] + sq_s3_q[1];
      k3_s4_q  <= K3_W'(pk_s3_q[0]) + (K3_W'(pk_s3_q[1]) << IN_W);
      mag_s4_q <= mag_s3_q;
      neg_s4_q <= neg_s3_q;

      side_q.k3  <= k3_s4_q;
      side_q.mag <= mag_s4_q;
      side_q.neg <= neg_s4_q;
      side_q.app <= d2_s4_q > D2_W'(min_sq_q);
      d2_q       <= d2_s4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign d2_o    = d2_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/gpf_isqrt.sv
// ----------------------------------------------------------------------------
// gpf_isqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence on the remainder,
// with the rest of the item carried alongside.
// ----------------------------------------------------------------------------
module gpf_isqrt import gpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [D2_W-1:0]   x_i,
  input  gpf_side_t         side_i,
  output logic              valid_o,
  output logic [DIST_W-1:0] dist_o,
  output gpf_side_t         side_o
);

  logic [SQ_STAGES-1:0]  vld_q;
  logic [SQ_REM_W-1:0]   rem_q   [SQ_STAGES];
  logic [ROOT_W-1:0]     root_q  [SQ_STAGES];
  gpf_side_t             side_q  [SQ_STAGES];
  logic [SQ_REM_W-1:0]   st_rem  [SQ_STAGES];
  logic [ROOT_W-1:0]     st_root [SQ_STAGES];
  gpf_side_t             st_side [SQ_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQ_STAGES-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - s;
    logic [SQ_REM_W-1:0] trial;
    logic                take;

    if (s == 0) begin : g_first
      assign st_rem[s]  = SQ_REM_W'(x_i);
      assign st_root[s] = '0;
      assign st_side[s] = side_i;
    end else begin : g_next
      assign st_rem[s]  = rem_q[s-1];
      assign st_root[s] = root_q[s-1];
      assign st_side[s] = side_q[s-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign trial = (SQ_REM_W'(st_root[s]) << (B + 1)) | (SQ_REM_W'(1) << (2 * B));
    assign take  = st_rem[s] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? st_rem[s] - trial : st_rem[s];
        root_q[s] <= take ? st_root[s] | (ROOT_W'(1) << B) : st_root[s];
        side_q[s] <= st_side[s];
      end
    end
  end

  assign valid_o = vld_q[SQ_STAGES-1];
  assign dist_o  = root_q[SQ_STAGES-1][DIST_W-1:0];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

FILE: rtl/gpf_mul.sv
// ----------------------------------------------------------------------------
// gpf_mul: numerator and cube of the distance
// Four stages: partial products, numerator sum and cube partials, cube sum,
// quotient range check ahead of the divider.
// ----------------------------------------------------------------------------
module gpf_mul import gpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DIST_W-1:0] dist_i,
  input  gpf_side_t         side_i,
  output logic              valid_o,
  output gpf_prod_t         prod_o
);

  logic [3:0]                 vld_q;
  logic [DC_W-1:0]            dsq_c1_q;
  logic [DIST_W-1:0]          dist_c1_q;
  logic [1:0][2:0][PX_W-1:0]  px_c1_q;
  logic [1:0]                 neg_c1_q, neg_c2_q, neg_c3_q;
  logic                       app_c1_q, app_c2_q, app_c3_q;
  logic [1:0][NUM_W-1:0]      num_c2_q, num_c3_q;
  logic [1:0][DC_W-1:0]       dp_c2_q;
  logic [DEN_W-1:0]           den_c3_q;
  gpf_prod_t                  prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsq_c1_q  <= DC_W'(dist_i) * DC_W'(dist_i);
      dist_c1_q <= dist_i;
      for (int l = 0; l < 2; l++) begin
        for (int w = 0; w < 3; w++) begin
          px_c1_q[l][w] <= PX_W'(side_i.k3[IN_W*w +: IN_W]) * PX_W'(side_i.mag[l]);
        end
      end
      neg_c1_q <= side_i.neg;
      app_c1_q <= side_i.app;

      for (int l = 0; l < 2; l++) begin
        num_c2_q[l] <= NUM_W'(px_c1_q[l][0])
                     + (NUM_W'(px_c1_q[l][1]) << IN_W)
                     + (NUM_W'(px_c1_q[l][2]) << (2 * IN_W));
      end
      dp_c2_q[0] <= DC_W'(dsq_c1_q[DIST_W-1:0]) * DC_W'(dist_c1_q);
      dp_c2_q[1] <= DC_W'(dsq_c1_q[DC_W-1:DIST_W]) * DC_W'(dist_c1_q);
      neg_c2_q   <= neg_c1_q;
      app_c2_q   <= app_c1_q;

      den_c3_q <= DEN_W'(dp_c2_q[0]) + (DEN_W'(dp_c2_q[1]) << DIST_W);
      num_c3_q <= num_c2_q;
      neg_c3_q <= neg_c2_q;
      app_c3_q <= app_c2_q;

      // quotient of 2^Q_W or more is clamped whatever its low bits
      for (int l = 0; l < 2; l++) begin
        prod_q.big[l] <= DEN_W'(num_c3_q[l][NUM_W-1:Q_W]) >= den_c3_q;
      end
      prod_q.num <= num_c3_q;
      prod_q.den <= den_c3_q;
      prod_q.neg <= neg_c3_q;
      prod_q.app <= app_c3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign prod_o  = prod_q;

endmodule

FILE: rtl/gpf_div.sv
// ----------------------------------------------------------------------------
// gpf_div: pipelined restoring divider, two lanes
// One quotient bit per stage for the x and y numerators over the shared
// cube of the distance.
// ----------------------------------------------------------------------------
module gpf_div import gpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  gpf_prod_t prod_i,
  output logic      valid_o,
  output gpf_quot_t quot_o
);

  logic [Q_W-1:0] vld_q;
  gpf_dstage_t    st_q  [Q_W];
  gpf_dstage_t    st_in [Q_W];
  gpf_dstage_t    first;

  always_comb begin
    first = '0;
    for (int l = 0; l < 2; l++) begin
      // upper part is below den when not flagged big
      first.lane[l].rem = DREM_W'(prod_i.num[l][NUM_W-1:Q_W]);
      first.lane[l].low = prod_i.num[l][Q_W-1:0];
      first.lane[l].q   = '0;
    end
    first.den = prod_i.den;
    first.neg = prod_i.neg;
    first.big = prod_i.big;
    first.app = prod_i.app;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    gpf_dstage_t nxt;

    if (s == 0) begin : g_first
      assign st_in[s] = first;
    end else begin : g_next
      assign st_in[s] = st_q[s-1];
    end

    always_comb begin
      logic [DREM_W-1:0] sh;
      logic              take;
      nxt = st_in[s];
      for (int l = 0; l < 2; l++) begin
        sh   = {st_in[s].lane[l].rem[DREM_W-2:0], st_in[s].lane[l].low[Q_W-1]};
        take = sh >= DREM_W'(st_in[s].den);
        nxt.lane[l].rem = take ? sh - DREM_W'(st_in[s].den) : sh;
        nxt.lane[l].low = {st_in[s].lane[l].low[Q_W-2:0], 1'b0};
        nxt.lane[l].q   = {st_in[s].lane[l].q[Q_W-2:0], take};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= nxt;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quot_o.q[l] = st_q[Q_W-1].lane[l].q;
    end
    quot_o.neg = st_q[Q_W-1].neg;
    quot_o.big = st_q[Q_W-1].big;
    quot_o.app = st_q[Q_W-1].app;
  end

  assign valid_o = vld_q[Q_W-1];

endmodule

FILE: rtl/gravity_pair_force.sv
// ----------------------------------------------------------------------------
// gravity_pair_force: newtonian gravity between two point bodies
// stages from input item to result item: 5 front stages, 34 square
// root stages, 4 multiply stages, 48 divider stages, 1 output register
// throughput one item per cycle unless stalled; the 48-stage divider is the
// deepest section; the whole pipeline holds while the output item is stalled
// reset (async, active low) clears all valid bits and loads grav_const = 1.0
// and the minimum separation = 5.0; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module gravity_pair_force import gpf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input item channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  body_a_x_i,
  input  logic signed [IN_W-1:0]  body_a_y_i,
  input  logic [IN_W-1:0]         body_a_mass_i,
  input  logic signed [IN_W-1:0]  body_b_x_i,
  input  logic signed [IN_W-1:0]  body_b_y_i,
  input  logic [IN_W-1:0]         body_b_mass_i,
  // result item channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] force_x_o,
  output logic signed [OUT_W-1:0] force_y_o,
  output logic                    applied_o,
  output logic                    saturated_o,
  // register writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [IN_W-1:0]         cfg_data_i
);

  logic                  en;
  logic [IN_W-1:0]       grav_const_q, min_sep_q;

  logic                  fr_valid;
  logic [D2_W-1:0]       fr_d2;
  gpf_side_t             fr_side;
  logic                  sq_valid;
  logic [DIST_W-1:0]     sq_dist;
  gpf_side_t             sq_side;
  logic                  mu_valid;
  gpf_prod_t             mu_prod;
  logic                  dv_valid;
  gpf_quot_t             dv_quot;

  logic [1:0][OUT_W-1:0] force_d, force_q;
  logic                  applied_d, applied_q;
  logic                  saturated_d, saturated_q;
  logic                  out_valid_q;

  // one enable for every stage: move unless the output item is held
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // configuration registers; writes to other indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_const_q <= GRAV_RESET;
      min_sep_q    <= MIN_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == REG_GRAV_CONST) begin
        grav_const_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_MIN_SEP) begin
        min_sep_q <= cfg_data_i;
      end
    end
  end

  // displacement, squared distance, distance test, G*ma*mb
  gpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .a_x_i        (body_a_x_i),
    .a_y_i        (body_a_y_i),
    .a_mass_i     (body_a_mass_i),
    .b_x_i        (body_b_x_i),
    .b_y_i        (body_b_y_i),
    .b_mass_i     (body_b_mass_i),
    .grav_const_i (grav_const_q),
    .min_sep_i    (min_sep_q),
    .valid_o      (fr_valid),
    .d2_o         (fr_d2),
    .side_o       (fr_side)
  );

  // dist = floor(sqrt(d2))
  gpf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .x_i     (fr_d2),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .dist_o  (sq_dist),
    .side_o  (sq_side)
  );

  // numerators k3*|d| and denominator dist^3
  gpf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .dist_i  (sq_dist),
    .side_i  (sq_side),
    .valid_o (mu_valid),
    .prod_o  (mu_prod)
  );

  // truncating divide, both components side by side
  gpf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mu_valid),
    .prod_i  (mu_prod),
    .valid_o (dv_valid),
    .quot_o  (dv_quot)
  );

  // clamp to the signed 48-bit range, apply the sign, zero when not applied
  always_comb begin
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;
    logic [1:0]     cap;
    for (int l = 0; l < 2; l++) begin
      lim        = dv_quot.neg[l] ? NEG_LIMIT : POS_LIMIT;
      cap[l]     = dv_quot.big[l] || (dv_quot.q[l] > lim);
      mag        = cap[l] ? lim : dv_quot.q[l];
      force_d[l] = dv_quot.app ? (dv_quot.neg[l] ? OUT_W'(~mag + Q_W'(1)) : OUT_W'(mag))
                               : '0;
    end
    applied_d   = dv_quot.app;
    saturated_d = dv_quot.app && (cap != 2'b00);
  end

  // output register: holds the item while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      force_q     <= force_d;
      applied_q   <= applied_d;
      saturated_q <= saturated_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = force_q[0];
  assign force_y_o   = force_q[1];
  assign applied_o   = applied_q;
  assign saturated_o = saturated_q;

endmodule

FILE: verif/gravity_pair_force_tb.sv
// ----------------------------------------------------------------------------
// gravity_pair_force_tb: self-checking bench for the pair force pipeline
// Drives body pairs through the input item channel with random gaps, stalls
// the result channel at random, and compares every result item field by field
// with a bit-exact fixed-point predictor that runs beside the block. Register
// writes happen only with the pipeline drained.
// ----------------------------------------------------------------------------
module gravity_pair_force_tb;
  import gpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 120;    // longer than the full pipeline depth
  localparam logic [IN_W-1:0] Q_ONE   = IN_W'(1) << FRAC_BITS;
  // indexes beyond the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [OUT_W-1:0] fx;
    logic signed [OUT_W-1:0] fy;
    logic                    applied;
    logic                    saturated;
  } pair_force_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [IN_W-1:0] body_a_x_i = '0;
  logic signed [IN_W-1:0] body_a_y_i = '0;
  logic [IN_W-1:0]        body_a_mass_i = '0;
  logic signed [IN_W-1:0] body_b_x_i = '0;
  logic signed [IN_W-1:0] body_b_y_i = '0;
  logic [IN_W-1:0]        body_b_mass_i = '0;

  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] force_x_o;
  logic signed [OUT_W-1:0] force_y_o;
  logic                    applied_o;
  logic                    saturated_o;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [IN_W-1:0]      cfg_data_i = '0;

  gravity_pair_force u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .body_a_x_i    (body_a_x_i),
    .body_a_y_i    (body_a_y_i),
    .body_a_mass_i (body_a_mass_i),
    .body_b_x_i    (body_b_x_i),
    .body_b_y_i    (body_b_y_i),
    .body_b_mass_i (body_b_mass_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .force_x_o     (force_x_o),
    .force_y_o     (force_y_o),
    .applied_o     (applied_o),
    .saturated_o   (saturated_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mirror of the register file, follows every accepted write
  logic [IN_W-1:0] grav_mirror = GRAV_RESET;
  logic [IN_W-1:0] min_sep_mirror = MIN_RESET;

  pair_force_t expected_forces[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_max = 8;   // sender gap drawn per item, 0 turns it off
  int unsigned recv_stall_max = 8; // receiver stall drawn per item

  // one force component: sign * floor(num / den), clamped to 48 bits
  function automatic logic [OUT_W-1:0] clamp_component(input logic [127:0] num,
                                                       input logic [127:0] den,
                                                       input logic neg,
                                                       inout logic sat);
    logic [127:0] quot;
    logic [127:0] limit;
    quot  = num / den;
    limit = neg ? 128'(NEG_LIMIT) : 128'(POS_LIMIT);
    if (quot > limit) begin
      quot = limit;
      sat  = 1'b1;
    end
    return neg ? OUT_W'(-quot) : OUT_W'(quot);
  endfunction

  function automatic pair_force_t predict_pair(input logic [IN_W-1:0] ax, ay, ma,
                                               input logic [IN_W-1:0] bx, by, mb);
    logic signed [IN_W:0] dx, dy;
    logic [IN_W:0]        adx, ady;
    logic [65:0]          d2, lim;
    logic [67:0]          sq;
    logic [33:0]          root, cand;
    logic [127:0]         den, k3;
    logic                 sat;
    pair_force_t          res;
    dx  = {ax[IN_W-1], ax} - {bx[IN_W-1], bx};
    dy  = {ay[IN_W-1], ay} - {by[IN_W-1], by};
    adx = dx[IN_W] ? -dx : dx;
    ady = dy[IN_W] ? -dy : dy;
    d2  = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
    lim = 66'(min_sep_mirror) * 66'(min_sep_mirror);
    res = '0;
    if (d2 <= lim) return res;   // too close, nothing applied
    // bitwise floor square root
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'(1) << b);
      sq   = 68'(cand) * 68'(cand);
      if (sq <= 68'(d2)) root = cand;
    end
    den = 128'(root) * 128'(root) * 128'(root);
    k3  = 128'(grav_mirror) * 128'(ma) * 128'(mb);
    sat = 1'b0;
    res.fx        = clamp_component(k3 * 128'(adx), den, dx[IN_W], sat);
    res.fy        = clamp_component(k3 * 128'(ady), den, dy[IN_W], sat);
    res.applied   = 1'b1;
    res.saturated = sat;
    return res;
  endfunction

  // present one pair, valid stays up afterwards so back-to-back items flow
  task automatic send_pair(input logic [IN_W-1:0] ax, ay, ma, bx, by, mb);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    body_a_x_i    <= ax;
    body_a_y_i    <= ay;
    body_a_mass_i <= ma;
    body_b_x_i    <= bx;
    body_b_y_i    <= by;
    body_b_mass_i <= mb;
    expected_forces.push_back(predict_pair(ax, ay, ma, bx, by, mb));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender idles until every result has come back
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_forces.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IN_W-1:0] data);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_GRAV_CONST) grav_mirror = data;
    else if (idx == REG_MIN_SEP) min_sep_mirror = data;
  endtask

  // random pair: mostly bodies near each other so forces stay in range,
  // the rest fully random coordinates that mostly saturate
  task automatic send_random_pair();
    logic [IN_W-1:0] ax, ay, ma, mb, ox, oy;
    int unsigned     span;
    ax   = $urandom;
    ay   = $urandom;
    span = $urandom_range(2, 26);
    ox   = $urandom_range(0, (1 << span) - 1) - (1 << (span - 1));
    oy   = $urandom_range(0, (1 << span) - 1) - (1 << (span - 1));
    case ($urandom_range(0, 3))
      0: begin
        ma = $urandom;
        mb = $urandom;
        ox = $urandom;
        oy = $urandom;
      end
      1: begin
        ma = $urandom_range(0, 1 << 20);
        mb = $urandom_range(0, 1 << 20);
      end
      2: begin
        ma = $urandom;
        mb = $urandom_range(0, 1 << 18);
      end
      default: begin
        ma = $urandom >> $urandom_range(0, 31);
        mb = $urandom >> $urandom_range(0, 31);
      end
    endcase
    send_pair(ax, ay, ma, ax - ox, ay - oy, mb);
  endtask

  // edge cases under the reset register values
  task automatic test_reset_values();
    send_pair(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);           // same spot
    send_pair(5 * Q_ONE, '0, Q_ONE, '0, '0, Q_ONE);                // exactly at limit
    send_pair(5 * Q_ONE + 1, '0, Q_ONE, '0, '0, Q_ONE);            // just past it
    send_pair(3 * Q_ONE, 4 * Q_ONE, Q_ONE, '0, '0, Q_ONE);         // diagonal at limit
    send_pair(-10 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE, '0, '0, 7 * Q_ONE);
    send_pair(32'sh7fffffff, 32'sh80000000, '1, 32'sh80000000, 32'sh7fffffff, '1);
    send_pair(32'sh80000000, 32'sh7fffffff, '1, 32'sh7fffffff, 32'sh80000000, '1);
    send_pair(100 * Q_ONE, -50 * Q_ONE, '0, '0, '0, '1);           // massless body a
    send_pair(100 * Q_ONE, -50 * Q_ONE, '1, '0, '0, '0);           // massless body b
    send_pair(6 * Q_ONE, -6 * Q_ONE, '1, '0, '0, '1);              // both masses at maximum
    send_pair(-6 * Q_ONE, 6 * Q_ONE, '1, '0, '0, '1);
    send_pair(32'sh7fffffff, '0, 1, 32'sh80000000, '0, 1);         // vanishing force
  endtask

  // register extremes, including writes to unused indexes
  task automatic test_register_extremes();
    write_reg(REG_GRAV_CONST, '0);
    send_pair(20 * Q_ONE, 20 * Q_ONE, '1, '0, '0, '1);             // applied, zero force
    write_reg(REG_GRAV_CONST, '1);
    send_pair(20 * Q_ONE, 20 * Q_ONE, '1, '0, '0, '1);
    send_pair(32'sh40000000, '0, Q_ONE, '0, '0, Q_ONE);
    write_reg(REG_MIN_SEP, '0);
    send_pair(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);           // zero distance
    send_pair(1, '0, 1, '0, '0, 1);                                // one raw step
    write_reg(REG_MIN_SEP, '1);
    send_pair(32'sh7fffffff, 32'sh7fffffff, '1, 32'sh80000000, 32'sh80000000, '1);
    send_pair(32'sh7fffffff, '0, '1, 32'sh80000000, '0, '1);
    write_reg(REG_SPARE_LO, 32'h0);
    write_reg(REG_SPARE_HI, 32'h0);
    send_pair(32'sh7fffffff, 32'sh7fffffff, Q_ONE, 32'sh80000000, 32'sh80000000, Q_ONE);
  endtask

  // random pairs under one register setting
  task automatic test_random_setting(input logic [IN_W-1:0] grav, input logic [IN_W-1:0] dmin,
                                     input int unsigned count);
    write_reg(REG_GRAV_CONST, grav);
    write_reg(REG_MIN_SEP, dmin);
    for (int unsigned i = 0; i < count; i++) begin
      send_random_pair();
      // the sender waits once mid-phase for a fully empty pipeline
      if (i == count / 2) drain_pipeline();
    end
  endtask

  // full-rate streaming with neither side idling
  task automatic test_full_rate();
    send_gap_max   = 0;
    recv_stall_max = 0;
    for (int unsigned i = 0; i < 200; i++) send_random_pair();
    drain_pipeline();
    send_gap_max   = 8;
    recv_stall_max = 8;
  endtask

  // result side: random stall per item, compare with oldest expectation
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    pair_force_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: result item with nothing expected fx=%h fy=%h", $time,
                   force_x_o, force_y_o);
          mismatches++;
        end else begin
          want = expected_forces.pop_front();
          if (force_x_o !== want.fx) begin
            $display("%0t: force_x expected %h actual %h", $time, want.fx, force_x_o);
            mismatches++;
          end
          if (force_y_o !== want.fy) begin
            $display("%0t: force_y expected %h actual %h", $time, want.fy, force_y_o);
            mismatches++;
          end
          if (applied_o !== want.applied) begin
            $display("%0t: applied expected %b actual %b", $time, want.applied, applied_o);
            mismatches++;
          end
          if (saturated_o !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     saturated_o);
            mismatches++;
          end
        end
        stall_left = $urandom_range(0, recv_stall_max);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gravity_pair_force_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_register_extremes();
    test_random_setting(GRAV_RESET, MIN_RESET, 400);
    test_random_setting($urandom, $urandom_range(0, 1 << 20), 400);
    test_random_setting('1, '0, 300);
    test_random_setting($urandom_range(0, 1 << 12), '1, 300);
    test_full_rate();
    test_random_setting('0, $urandom_range(0, 1 << 24), 200);
    test_random_setting(GRAV_RESET, $urandom_range(0, 1 << 18), 200);

    drain_pipeline();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("gravity_pair_force_tb: PASS");
    end else begin
      $display("gravity_pair_force_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gpf_pkg.sv
rtl/gpf_front.sv
rtl/gpf_isqrt.sv
rtl/gpf_mul.sv
rtl/gpf_div.sv
rtl/gravity_pair_force.sv
verif/gravity_pair_force_tb.sv
